### rtl/fau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature accumulator update package
// Shared types, constants and codes for the accumulator update block.
// ----------------------------------------------------------------------------
package fau_pkg;

  localparam int unsigned AccWidth     = 256;
  localparam int unsigned BucketCount  = 8;
  localparam int unsigned FeatureCount = 1024;
  localparam int unsigned StackDepth   = 8;
  localparam int unsigned LanesPerWord = 16;

  localparam int unsigned WordsPerRow = AccWidth / LanesPerWord;
  localparam int unsigned WordBits    = $clog2(WordsPerRow);
  localparam int unsigned SubBits     = $clog2(LanesPerWord);
  localparam int unsigned FeatBits    = $clog2(FeatureCount);
  localparam int unsigned SlotBits    = $clog2(StackDepth);
  localparam int unsigned BktBits     = (BucketCount > 1) ? $clog2(BucketCount) : 1;

  // Main weight rows: one memory word holds LanesPerWord lanes.
  localparam int unsigned MainDepth  = FeatureCount * WordsPerRow;
  localparam int unsigned MainAbits  = $clog2(MainDepth);
  localparam int unsigned BwDepth    = FeatureCount * BucketCount;
  localparam int unsigned BwAbits    = $clog2(BwDepth);
  localparam int unsigned AccDepth   = StackDepth * 2 * WordsPerRow;
  localparam int unsigned AccAbits   = $clog2(AccDepth);
  localparam int unsigned SumDepth   = StackDepth * 2 * BucketCount;
  localparam int unsigned SumAbits   = $clog2(SumDepth);
  localparam int unsigned SqWordW    = 16 * LanesPerWord;
  localparam int unsigned ThWordW    = 8 * LanesPerWord;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    FUNC_WRITE_WEIGHT = 3'd0,
    FUNC_SET_ELEMENT  = 3'd1,
    FUNC_COPY_SLOT    = 3'd2,
    FUNC_ADD_FEATURE  = 3'd3,
    FUNC_SUB_FEATURE  = 3'd4,
    FUNC_READ         = 3'd5,
    FUNC_RSVD6        = 3'd6,
    FUNC_RSVD7        = 3'd7
  } func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic        perspective;
    logic        table_select;
    logic [9:0]  feature_index;
    logic [8:0]  lane;
    logic [31:0] value;
    logic [2:0]  target_slot;
    logic [2:0]  source_slot;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [8:0]  read_lane;
  } out_word_t;

  // Classified command handed from the front end to the execution engine.
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_SET   = 3'd1,
    OP_COPY  = 3'd2,
    OP_APPLY = 3'd3,
    OP_READ  = 3'd4,
    OP_RSVD5 = 3'd5,
    OP_RSVD6 = 3'd6,
    OP_RSVD7 = 3'd7
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic                 subtract;
    logic                 persp;
    logic                 tsel;
    logic [FeatBits-1:0]  feat;
    logic                 main_lane;
    logic                 bkt_lane;
    logic [WordBits-1:0]  word;
    logic [SubBits-1:0]   sub;
    logic [BktBits-1:0]   blane;
    logic [8:0]           lane;
    logic [31:0]          value;
    logic [SlotBits-1:0]  tslot;
    logic [SlotBits-1:0]  sslot;
    logic                 slot_ok;
  } cmd_t;

endpackage

### rtl/feature_accumulator_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature accumulator update
// Incremental accumulator engine with weight tables and a slot stack.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Word
//  in        input      in_valid_i/in_ready_o in_word_i (fau_pkg::in_word_t)
//  out       output     out_valid_o/out_ready_i out_word_o (fau_pkg::out_word_t)
//
// An accepted word is written into the queue and reaches the engine from there.
// A weight write or element set is taken in idle and written in the next state;
// a read addresses its element and loads the result register once the output is free.
// Add, remove and copy walk the row one 16-lane memory word at a time, read then
// write, and then the bucket words, each read then written; the single-port
// accumulator memory sets this.
// Reset clears only control state; memories are undefined until written.
// A two-entry command queue lets input words arrive while the engine works,
// and a result register holds a read answer while the output stalls.
// ----------------------------------------------------------------------------
module feature_accumulator_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fau_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fau_pkg::out_word_t out_word_o
);

  fau_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  // The front end decodes and drops items that change nothing.
  fau_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // The engine owns all memories and the output register.
  fau_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .out_word_o
  );

endmodule

### rtl/fau_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data, no reset.
// ----------------------------------------------------------------------------
module fau_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [Width-1:0]         wmask_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= (mem[addr_i] & ~wmask_i) | (wdata_i & wmask_i);
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### rtl/fau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts input words, decodes and range-checks them, and queues commands.
// ----------------------------------------------------------------------------
module fau_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fau_pkg::in_word_t  in_word_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output fau_pkg::cmd_t      cmd_o
);

  localparam int unsigned PtrBits = $clog2(fau_pkg::QueueDepth);

  fau_pkg::cmd_t         q_mem [fau_pkg::QueueDepth];
  logic [PtrBits-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]      cnt_q, cnt_d;
  fau_pkg::cmd_t         dec;
  logic                  keep, push, pop;
  logic                  feat_ok, tslot_ok, sslot_ok, main_lane, bkt_lane;
  logic [8:0]            boff;

  always_comb begin
    main_lane = in_word_i.lane < 9'(fau_pkg::AccWidth);
    boff      = in_word_i.lane - 9'(fau_pkg::AccWidth);
    bkt_lane  = !main_lane && (boff < 9'(fau_pkg::BucketCount));
    feat_ok   = {1'b0, in_word_i.feature_index} < 11'(fau_pkg::FeatureCount);
    tslot_ok  = {1'b0, in_word_i.target_slot} < 4'(fau_pkg::StackDepth);
    sslot_ok  = {1'b0, in_word_i.source_slot} < 4'(fau_pkg::StackDepth);

    dec.op        = fau_pkg::OP_WRITE;
    dec.subtract  = in_word_i.func == fau_pkg::FUNC_SUB_FEATURE;
    dec.persp     = in_word_i.perspective;
    dec.tsel      = in_word_i.table_select;
    dec.feat      = in_word_i.feature_index[fau_pkg::FeatBits-1:0];
    dec.main_lane = main_lane;
    dec.bkt_lane  = bkt_lane;
    dec.word      = in_word_i.lane[fau_pkg::SubBits +: fau_pkg::WordBits];
    dec.sub       = in_word_i.lane[fau_pkg::SubBits-1:0];
    dec.blane     = boff[fau_pkg::BktBits-1:0];
    dec.lane      = in_word_i.lane;
    dec.value     = in_word_i.value;
    dec.tslot     = in_word_i.target_slot[fau_pkg::SlotBits-1:0];
    dec.sslot     = in_word_i.source_slot[fau_pkg::SlotBits-1:0];
    dec.slot_ok   = tslot_ok;
    keep          = 1'b0;

    unique case (fau_pkg::func_e'(in_word_i.func))
      fau_pkg::FUNC_WRITE_WEIGHT: begin
        dec.op = fau_pkg::OP_WRITE;
        keep   = feat_ok && (main_lane || bkt_lane);
      end
      fau_pkg::FUNC_SET_ELEMENT: begin
        dec.op = fau_pkg::OP_SET;
        keep   = tslot_ok && (main_lane || bkt_lane);
      end
      fau_pkg::FUNC_COPY_SLOT: begin
        dec.op = fau_pkg::OP_COPY;
        keep   = tslot_ok && sslot_ok && (in_word_i.target_slot != in_word_i.source_slot);
      end
      fau_pkg::FUNC_ADD_FEATURE, fau_pkg::FUNC_SUB_FEATURE: begin
        dec.op = fau_pkg::OP_APPLY;
        keep   = feat_ok && tslot_ok;
      end
      fau_pkg::FUNC_READ: begin
        dec.op = fau_pkg::OP_READ;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o  = cnt_q != (PtrBits+1)'(fau_pkg::QueueDepth);
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = cnt_q != '0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/fau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execution engine
// Carries out queued commands against the weight and accumulator memories.
// ----------------------------------------------------------------------------
module fau_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  fau_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fau_pkg::out_word_t out_word_o
);

  localparam int unsigned LW  = fau_pkg::LanesPerWord;
  localparam int unsigned BS  = fau_pkg::BucketCount;
  localparam int unsigned StW = (fau_pkg::WordBits > fau_pkg::BktBits) ? fau_pkg::WordBits
                                                                       : fau_pkg::BktBits;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_WB   = 7'b0000010,
    ST_OUT  = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_WR   = 7'b0010000,
    ST_BRD  = 7'b0100000,
    ST_BWR  = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  fau_pkg::cmd_t                  cmd_q, cmd_d;
  logic [StW-1:0]                 step_q, step_d;   // word index, then bucket index
  logic [31:0]                    rval;
  fau_pkg::out_word_t             out_q;
  logic                           out_v_q, out_v_d;

  // Memory ports.
  logic                           sq_we, th_we, sb_we, tb_we, ac_we, su_we;
  logic [fau_pkg::MainAbits-1:0]  w_addr;
  logic [fau_pkg::BwAbits-1:0]    bw_addr;
  logic [fau_pkg::AccAbits-1:0]   ac_addr;
  logic [fau_pkg::SumAbits-1:0]   su_addr;
  logic [fau_pkg::SqWordW-1:0]    sq_wd, sq_wm, sq_rd, ac_wd, ac_wm, ac_rd;
  logic [fau_pkg::ThWordW-1:0]    th_wd, th_wm, th_rd;
  logic [31:0]                    sb_rd, tb_rd, su_rd, su_wd;
  logic [fau_pkg::SqWordW-1:0]    row_w, sum_w;
  logic [31:0]                    bw, bsum;
  logic [fau_pkg::SlotBits:0]     slot_sel;
  logic [fau_pkg::WordBits-1:0]   wstep;
  logic [fau_pkg::BktBits-1:0]    bstep;
  logic                           last_word, last_bkt;

  fau_ram #(.Width(fau_pkg::SqWordW), .Depth(fau_pkg::MainDepth)) u_sq (
    .clk_i, .we_i(sq_we), .addr_i(w_addr), .wdata_i(sq_wd), .wmask_i(sq_wm), .rdata_o(sq_rd));
  fau_ram #(.Width(fau_pkg::ThWordW), .Depth(fau_pkg::MainDepth)) u_th (
    .clk_i, .we_i(th_we), .addr_i(w_addr), .wdata_i(th_wd), .wmask_i(th_wm), .rdata_o(th_rd));
  fau_ram #(.Width(32), .Depth(fau_pkg::BwDepth)) u_sb (
    .clk_i, .we_i(sb_we), .addr_i(bw_addr), .wdata_i(cmd_q.value), .wmask_i('1),
    .rdata_o(sb_rd));
  fau_ram #(.Width(32), .Depth(fau_pkg::BwDepth)) u_tb (
    .clk_i, .we_i(tb_we), .addr_i(bw_addr), .wdata_i(cmd_q.value), .wmask_i('1),
    .rdata_o(tb_rd));
  fau_ram #(.Width(fau_pkg::SqWordW), .Depth(fau_pkg::AccDepth)) u_ac (
    .clk_i, .we_i(ac_we), .addr_i(ac_addr), .wdata_i(ac_wd), .wmask_i(ac_wm), .rdata_o(ac_rd));
  fau_ram #(.Width(32), .Depth(fau_pkg::SumDepth)) u_su (
    .clk_i, .we_i(su_we), .addr_i(su_addr), .wdata_i(su_wd), .wmask_i('1), .rdata_o(su_rd));

  assign wstep     = step_q[fau_pkg::WordBits-1:0];
  assign bstep     = step_q[fau_pkg::BktBits-1:0];
  assign last_word = wstep == fau_pkg::WordBits'(fau_pkg::WordsPerRow - 1);
  assign last_bkt  = bstep == fau_pkg::BktBits'(BS - 1);

  // A copy reads from the source slot in its read phases, all else uses target.
  always_comb begin
    slot_sel = {cmd_q.tslot, cmd_q.persp};
    if (cmd_q.op == fau_pkg::OP_COPY && (state_q == ST_RD || state_q == ST_BRD)) begin
      slot_sel = {cmd_q.sslot, cmd_q.persp};
    end
  end

  // Weight row word widened to 16-bit lanes, and the lane-wise sum.
  always_comb begin
    for (int i = 0; i < LW; i++) begin
      row_w[16*i +: 16] = cmd_q.tsel ? {{8{th_rd[8*i+7]}}, th_rd[8*i +: 8]}
                                     : sq_rd[16*i +: 16];
      sum_w[16*i +: 16] = cmd_q.subtract ? ac_rd[16*i +: 16] - row_w[16*i +: 16]
                                         : ac_rd[16*i +: 16] + row_w[16*i +: 16];
    end
    bw   = cmd_q.tsel ? tb_rd : sb_rd;
    bsum = cmd_q.subtract ? su_rd - bw : su_rd + bw;
  end

  // Read answer, taken from the element addressed in the previous cycle.
  always_comb begin
    rval = '0;
    if (cmd_q.slot_ok && cmd_q.main_lane) begin
      rval = {{16{ac_rd[16*cmd_q.sub+15]}}, ac_rd[16*cmd_q.sub +: 16]};
    end else if (cmd_q.slot_ok && cmd_q.bkt_lane) begin
      rval = su_rd;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    step_d   = step_q;
    out_v_d  = out_v_q && !out_ready_i;
    sq_we    = 1'b0;
    th_we    = 1'b0;
    sb_we    = 1'b0;
    tb_we    = 1'b0;
    ac_we    = 1'b0;
    su_we    = 1'b0;
    w_addr   = {cmd_q.feat, wstep};
    bw_addr  = {cmd_q.feat, bstep};
    ac_addr  = {slot_sel, wstep};
    su_addr  = {slot_sel, bstep};
    sq_wd    = {LW{cmd_q.value[15:0]}};
    th_wd    = {LW{cmd_q.value[7:0]}};
    ac_wd    = {LW{cmd_q.value[15:0]}};
    su_wd    = cmd_q.value;
    sq_wm    = '0;
    th_wm    = '0;
    ac_wm    = '0;
    sq_wm[16*cmd_q.sub +: 16] = '1;
    th_wm[8*cmd_q.sub +: 8]   = '1;
    ac_wm[16*cmd_q.sub +: 16] = '1;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          step_d = '0;
          if (cmd_i.op == fau_pkg::OP_COPY || cmd_i.op == fau_pkg::OP_APPLY) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_WB;
          end
        end
      end
      ST_WB: begin
        // Single-element commands: write now, or address the element for ST_OUT to collect.
        unique case (cmd_q.op)
          fau_pkg::OP_WRITE: begin
            w_addr  = {cmd_q.feat, cmd_q.word};
            bw_addr = {cmd_q.feat, cmd_q.blane};
            sq_we   = cmd_q.main_lane && !cmd_q.tsel;
            th_we   = cmd_q.main_lane && cmd_q.tsel;
            sb_we   = cmd_q.bkt_lane && !cmd_q.tsel;
            tb_we   = cmd_q.bkt_lane && cmd_q.tsel;
            state_d = ST_IDLE;
          end
          fau_pkg::OP_SET: begin
            ac_addr = {cmd_q.tslot, cmd_q.persp, cmd_q.word};
            su_addr = {cmd_q.tslot, cmd_q.persp, cmd_q.blane};
            ac_we   = cmd_q.main_lane;
            su_we   = cmd_q.bkt_lane;
            state_d = ST_IDLE;
          end
          default: begin
            ac_addr = {cmd_q.tslot, cmd_q.persp, cmd_q.word};
            su_addr = {cmd_q.tslot, cmd_q.persp, cmd_q.blane};
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        // Keep the element addressed so the read data holds while the output stalls.
        ac_addr = {cmd_q.tslot, cmd_q.persp, cmd_q.word};
        su_addr = {cmd_q.tslot, cmd_q.persp, cmd_q.blane};
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        // Read one row word and its weights; data is ready next cycle.
        state_d = ST_WR;
      end
      ST_WR: begin
        ac_addr = {cmd_q.tslot, cmd_q.persp, wstep};
        ac_we   = 1'b1;
        ac_wm   = '1;
        ac_wd   = (cmd_q.op == fau_pkg::OP_COPY) ? ac_rd : sum_w;
        if (last_word) begin
          step_d  = '0;
          state_d = ST_BRD;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_BRD: begin
        state_d = ST_BWR;
      end
      ST_BWR: begin
        su_addr = {cmd_q.tslot, cmd_q.persp, bstep};
        su_we   = 1'b1;
        su_wd   = (cmd_q.op == fau_pkg::OP_COPY) ? su_rd : bsum;
        if (last_bkt) begin
          state_d = ST_IDLE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_BRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (state_q == ST_OUT && (!out_v_q || out_ready_i)) begin
      out_q.read_value <= rval;
      out_q.read_lane  <= cmd_q.lane;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

### rtl/fau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports for handshake and result sanity.
// ----------------------------------------------------------------------------
module fau_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  fau_pkg::in_word_t  in_word_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  fau_pkg::out_word_t out_word_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result changed while stalled");

  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.read_lane >= 9'(fau_pkg::AccWidth + fau_pkg::BucketCount)
    |-> out_word_o.read_value == '0)
    else $error("out-of-range lane gave a nonzero value");

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_ready_o) && !$isunknown(out_valid_o))
    else $error("handshake output unknown");

endmodule

bind feature_accumulator_update fau_checker u_fau_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature accumulator update testbench
// Drives words through the valid/ready input channel and tracks the weight
// tables and accumulator slots in a local predictor. Every read answer is
// compared field by field with the oldest predicted answer. A directed
// table with hand-written answers comes first. Then a pass writes whole
// weight rows for one feature of each table and fills every accumulator slot,
// so that no store entry is read before it is written. A random phase
// with idling on both sides, a long output stall and a drain pause follows.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomWords   = 700;
  localparam int unsigned RowLanes      = fau_pkg::AccWidth + fau_pkg::BucketCount;
  localparam int unsigned AccW          = fau_pkg::AccWidth;
  localparam int unsigned BktN          = fau_pkg::BucketCount;

  // Features whose rows are fully written and may be added or removed.
  localparam bit [9:0] SqFeat = 10'h3FF;
  localparam bit [9:0] ThFeat = 10'h155;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  fau_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  fau_pkg::out_word_t out_word_o;

  feature_accumulator_update dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  // Local copy of every store, kept at the block's element widths.
  bit [15:0] sq_row_mem [0:fau_pkg::FeatureCount*AccW-1];
  bit [7:0]  th_row_mem [0:fau_pkg::FeatureCount*AccW-1];
  bit [31:0] sq_bkt_mem [0:fau_pkg::FeatureCount*BktN-1];
  bit [31:0] th_bkt_mem [0:fau_pkg::FeatureCount*BktN-1];
  bit [15:0] acc_mem    [0:fau_pkg::StackDepth*2*AccW-1];
  bit [31:0] bsum_mem   [0:fau_pkg::StackDepth*2*BktN-1];

  fau_pkg::out_word_t pending_reads[$];
  int                 errors = 0;
  bit                 no_idle = 1'b0;
  bit                 hold_req = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Applies one accepted word to the local stores and returns the read
  // answer it causes, if any.
  task automatic predict_accumulator(input fau_pkg::in_word_t w, output bit has_read,
                                     output fau_pkg::out_word_t ans);
    int unsigned abase, sbase, tb_acc, tb_sum, wrow, brow, lane;
    bit [15:0] wt;
    bit [31:0] bw;
    abase = (w.target_slot * 2 + w.perspective) * AccW;
    sbase = (w.target_slot * 2 + w.perspective) * BktN;
    wrow  = w.feature_index * AccW;
    brow  = w.feature_index * BktN;
    lane  = w.lane;
    has_read = 1'b0;
    ans = '0;
    case (fau_pkg::func_e'(w.func))
      fau_pkg::FUNC_WRITE_WEIGHT: begin
        if (lane < AccW) begin
          if (w.table_select) th_row_mem[wrow + lane] = w.value[7:0];
          else sq_row_mem[wrow + lane] = w.value[15:0];
        end else if (lane < RowLanes) begin
          if (w.table_select) th_bkt_mem[brow + lane - AccW] = w.value;
          else sq_bkt_mem[brow + lane - AccW] = w.value;
        end
      end
      fau_pkg::FUNC_SET_ELEMENT: begin
        if (lane < AccW) acc_mem[abase + lane] = w.value[15:0];
        else if (lane < RowLanes) bsum_mem[sbase + lane - AccW] = w.value;
      end
      fau_pkg::FUNC_COPY_SLOT: begin
        tb_acc = (w.source_slot * 2 + w.perspective) * AccW;
        tb_sum = (w.source_slot * 2 + w.perspective) * BktN;
        if (w.source_slot != w.target_slot) begin
          for (int i = 0; i < AccW; i++) acc_mem[abase + i] = acc_mem[tb_acc + i];
          for (int i = 0; i < BktN; i++) bsum_mem[sbase + i] = bsum_mem[tb_sum + i];
        end
      end
      fau_pkg::FUNC_ADD_FEATURE, fau_pkg::FUNC_SUB_FEATURE: begin
        for (int i = 0; i < AccW; i++) begin
          wt = w.table_select ? {{8{th_row_mem[wrow + i][7]}}, th_row_mem[wrow + i]}
                              : sq_row_mem[wrow + i];
          acc_mem[abase + i] = (w.func == fau_pkg::FUNC_SUB_FEATURE)
                               ? acc_mem[abase + i] - wt : acc_mem[abase + i] + wt;
        end
        for (int i = 0; i < BktN; i++) begin
          bw = w.table_select ? th_bkt_mem[brow + i] : sq_bkt_mem[brow + i];
          bsum_mem[sbase + i] = (w.func == fau_pkg::FUNC_SUB_FEATURE)
                                ? bsum_mem[sbase + i] - bw : bsum_mem[sbase + i] + bw;
        end
      end
      fau_pkg::FUNC_READ: begin
        has_read = 1'b1;
        ans.read_lane = w.lane;
        if (lane < AccW)
          ans.read_value = {{16{acc_mem[abase + lane][15]}}, acc_mem[abase + lane]};
        else if (lane < RowLanes)
          ans.read_value = bsum_mem[sbase + lane - AccW];
      end
      default: ;
    endcase
  endtask

  function automatic fau_pkg::in_word_t mk(fau_pkg::func_e f, bit p, bit ts, bit [9:0] feat,
                                           bit [8:0] lane, bit [31:0] v, bit [2:0] tsl,
                                           bit [2:0] ssl);
    fau_pkg::in_word_t w;
    w.func = f;
    w.perspective = p;
    w.table_select = ts;
    w.feature_index = feat;
    w.lane = lane;
    w.value = v;
    w.target_slot = tsl;
    w.source_slot = ssl;
    return w;
  endfunction

  // Offers one word, waits for its acceptance and records what it predicts.
  // A literal answer, where given, replaces the predicted one.
  task automatic send_word(input fau_pkg::in_word_t w, input bit lit,
                           input bit [31:0] lit_val);
    int unsigned gap;
    bit has_read;
    fau_pkg::out_word_t ans;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_accumulator(w, has_read, ans);
    if (has_read) begin
      if (lit) ans.read_value = lit_val;
      pending_reads.push_back(ans);
    end
  endtask

  function automatic bit [8:0] rand_lane();
    if ($urandom_range(0, 9) == 0) return 9'($urandom_range(RowLanes, 511));
    return 9'($urandom_range(0, RowLanes - 1));
  endfunction

  function automatic bit [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random words: mostly well-formed updates over initialized state.
  function automatic fau_pkg::in_word_t rand_word();
    fau_pkg::in_word_t w;
    int unsigned pick;
    bit ts;
    w = mk(fau_pkg::FUNC_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           10'($urandom), rand_lane(), rand_value(), 3'($urandom), 3'($urandom));
    ts = w.table_select;
    pick = $urandom_range(0, 99);
    if (pick < 25) w.func = fau_pkg::FUNC_READ;
    else if (pick < 40) w.func = fau_pkg::FUNC_SET_ELEMENT;
    else if (pick < 55) begin
      w.func = fau_pkg::FUNC_WRITE_WEIGHT;
      if ($urandom_range(0, 1)) w.feature_index = ts ? ThFeat : SqFeat;
    end else if (pick < 65) w.func = fau_pkg::FUNC_COPY_SLOT;
    else if (pick < 95) begin
      w.func = $urandom_range(0, 1) ? fau_pkg::FUNC_ADD_FEATURE : fau_pkg::FUNC_SUB_FEATURE;
      w.feature_index = ts ? ThFeat : SqFeat;
    end else w.func = $urandom_range(0, 1) ? fau_pkg::FUNC_RSVD6 : fau_pkg::FUNC_RSVD7;
    return w;
  endfunction

  typedef struct {
    fau_pkg::in_word_t w;
    bit                lit;
    bit [31:0]         ans;
  } row_t;

  row_t directed[$];

  // Output side: random idling, one long hold-off on request, and the check.
  initial begin
    int unsigned gap;
    fau_pkg::out_word_t exp_w;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        gap = 400;
        hold_req = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_reads.size() == 0) begin
        report($sformatf("read answer %h lane %0d with none expected",
                         out_word_o.read_value, out_word_o.read_lane));
      end else begin
        exp_w = pending_reads.pop_front();
        if (out_word_o.read_value !== exp_w.read_value)
          report($sformatf("read_value %h, expected %h (lane %0d)",
                           out_word_o.read_value, exp_w.read_value, exp_w.read_lane));
        if (out_word_o.read_lane !== exp_w.read_lane)
          report($sformatf("read_lane %0d, expected %0d",
                           out_word_o.read_lane, exp_w.read_lane));
      end
    end
  end

  // Watchdog on cycles in which neither channel accepts a word.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit [9:0] feat;
    // Directed rows: extremes, truncation, lanes out of range, unused codes.
    directed.push_back('{mk(fau_pkg::FUNC_SET_ELEMENT, 0, 0, 0, 0, 32'h0000_7FFF, 0, 0), 0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, 32'h0000_7FFF});
    directed.push_back('{mk(fau_pkg::FUNC_SET_ELEMENT, 1, 1, 10'h3FF, 255, 32'hDEAD_8000, 7, 7),
                         0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 1, 1, 10'h3FF, 255, 32'hFFFF_FFFF, 7, 7), 1,
                         32'hFFFF_8000});
    directed.push_back('{mk(fau_pkg::FUNC_SET_ELEMENT, 0, 0, 0, 2, 32'hDEAD_1234, 0, 0), 0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 0, 0, 0, 2, 0, 0, 0), 1, 32'h0000_1234});
    directed.push_back('{mk(fau_pkg::FUNC_SET_ELEMENT, 0, 0, 0, 256, 32'h8000_0000, 0, 0), 0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 0, 0, 0, 256, 0, 0, 0), 1, 32'h8000_0000});
    directed.push_back('{mk(fau_pkg::FUNC_SET_ELEMENT, 1, 0, 0, 263, 32'hFFFF_FFFF, 7, 0), 0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 1, 0, 0, 263, 0, 7, 0), 1, 32'hFFFF_FFFF});
    // A lane past the buckets reads as zero and writes nothing.
    directed.push_back('{mk(fau_pkg::FUNC_READ, 0, 0, 0, 511, 0, 3, 0), 1, 32'h0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 1, 0, 0, 264, 0, 5, 0), 1, 32'h0});
    directed.push_back('{mk(fau_pkg::FUNC_SET_ELEMENT, 0, 0, 0, 400, 32'h1111_1111, 0, 0), 0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_WRITE_WEIGHT, 0, 0, 10'h3FF, 300, 32'h2222_2222, 0, 0),
                         0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, 32'h0000_7FFF});
    // Unused codes must leave the slots alone and answer nothing.
    directed.push_back('{mk(fau_pkg::FUNC_RSVD6, 1, 1, 10'h3FF, 9'h1FF, 32'hFFFF_FFFF, 7, 7),
                         0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_RSVD7, 1, 1, 10'h3FF, 0, 32'hFFFF_FFFF, 0, 7), 0, 0});
    directed.push_back('{mk(fau_pkg::FUNC_READ, 1, 0, 0, 263, 0, 7, 0), 1, 32'hFFFF_FFFF});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i].w, directed[i].lit, directed[i].ans);

    // Fill the whole row of one feature per table, then slot 0 of both sides,
    // then copy slot 0 into every other slot so all accumulator state is defined.
    for (int t = 0; t < 2; t++) begin
      feat = t ? ThFeat : SqFeat;
      for (int l = 0; l < RowLanes; l++)
        send_word(mk(fau_pkg::FUNC_WRITE_WEIGHT, 1'($urandom_range(0, 1)), 1'(t), feat,
                     9'(l), $urandom, 3'($urandom), 3'($urandom)), 0, 0);
    end
    for (int p = 0; p < 2; p++)
      for (int l = 0; l < RowLanes; l++)
        send_word(mk(fau_pkg::FUNC_SET_ELEMENT, 1'(p), 1'($urandom_range(0, 1)),
                     10'($urandom), 9'(l), rand_value(), 3'(0), 3'($urandom)), 0, 0);
    for (int p = 0; p < 2; p++)
      for (int s = 1; s < fau_pkg::StackDepth; s++)
        send_word(mk(fau_pkg::FUNC_COPY_SLOT, 1'(p), 1'($urandom_range(0, 1)),
                     10'($urandom), 9'($urandom), $urandom, 3'(s), 3'(0)), 0, 0);

    for (int n = 0; n < RandomWords; n++) begin
      no_idle = ((n / 150) % 4) == 1;
      if (n == 250) hold_req = 1'b1;
      if (n == 500) begin
        // Wait for every pending read answer, then pause, before going on.
        in_valid_i <= 1'b0;
        while (pending_reads.size() > 0) @(posedge clk_i);
        repeat (60) @(posedge clk_i);
      end
      send_word(rand_word(), 0, 0);
    end
    in_valid_i <= 1'b0;

    while (pending_reads.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
